/* rtl/lwi_pkg.sv */
package lwi_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int MAX_WAYPOINTS = 63;

    localparam int IDX_WIDTH     = 6;
    localparam int PARTS_WIDTH   = IDX_WIDTH + 1;
    localparam int REM_WIDTH     = IDX_WIDTH + 2;
    localparam int CFG_IDX_WIDTH = 3;

    localparam int NUM_WAYPOINTS_RESET = 5;
    localparam int HOME_X_UNITS        = 1;
    localparam int HOME_Y_UNITS        = 2;
    localparam int HOME_Z_UNITS        = 3;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_NUM_WAYPOINTS = 3'd0,
        REG_HOME_X        = 3'd1,
        REG_HOME_Y        = 3'd2,
        REG_HOME_Z        = 3'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PRIME,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div;
        logic step;
    } t_lane_ctl;

endpackage

/* rtl/lwi_lane.sv */
module lwi_lane #(
    parameter int COORD_WIDTH = lwi_pkg::COORD_WIDTH
) (
    input  logic                                 i_clk,
    input  lwi_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [COORD_WIDTH-1:0]        i_start,
    input  logic signed [COORD_WIDTH-1:0]        i_target,
    input  logic [lwi_pkg::PARTS_WIDTH-1:0]      i_parts,
    output logic signed [COORD_WIDTH-1:0]        o_coord
);

    localparam int MAG_W = COORD_WIDTH + 1;
    localparam int REM_W = lwi_pkg::REM_WIDTH;

    logic                     r_neg;
    logic [MAG_W-1:0]         r_quo;
    logic [REM_W-1:0]         r_rem;
    logic [REM_W-1:0]         r_acc_rem;
    logic [COORD_WIDTH-1:0]   r_coord;

    logic signed [MAG_W-1:0]  w_diff;
    logic [MAG_W-1:0]         w_mag;
    logic [REM_W-1:0]         w_divisor;
    logic [REM_W-1:0]         w_trial;
    logic                     w_fits;
    logic [REM_W-1:0]         w_sum;
    logic                     w_carry;
    logic [MAG_W-1:0]         w_delta;

    assign w_diff    = {i_target[COORD_WIDTH-1], i_target} - {i_start[COORD_WIDTH-1], i_start};
    assign w_mag     = w_diff[MAG_W-1] ? MAG_W'(-w_diff) : MAG_W'(w_diff);
    assign w_divisor = {1'b0, i_parts};
    assign w_trial   = {r_rem[REM_W-2:0], r_quo[MAG_W-1]};
    assign w_fits    = (w_trial >= w_divisor);
    assign w_sum     = r_acc_rem + r_rem;
    assign w_carry   = (w_sum >= w_divisor);
    assign w_delta   = r_quo + MAG_W'(w_carry);
    assign o_coord   = r_coord;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_neg     <= w_diff[MAG_W-1];
            r_quo     <= w_mag;
            r_rem     <= '0;
            r_acc_rem <= '0;
            r_coord   <= i_start;
        end else if (i_ctl.div) begin
            r_quo <= {r_quo[MAG_W-2:0], w_fits};
            r_rem <= w_fits ? (w_trial - w_divisor) : w_trial;
        end else if (i_ctl.step) begin
            r_acc_rem <= w_carry ? (w_sum - w_divisor) : w_sum;
            if (r_neg) begin
                r_coord <= r_coord - w_delta[COORD_WIDTH-1:0];
            end else begin
                r_coord <= r_coord + w_delta[COORD_WIDTH-1:0];
            end
        end
    end

endmodule

/* rtl/lwi_merge.sv */
module lwi_merge #(
    parameter int COORD_WIDTH = lwi_pkg::COORD_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_load,
    input  logic signed [COORD_WIDTH-1:0]      i_x,
    input  logic signed [COORD_WIDTH-1:0]      i_y,
    input  logic signed [COORD_WIDTH-1:0]      i_z,
    input  logic [lwi_pkg::IDX_WIDTH-1:0]      i_index,
    input  logic                               i_last,
    input  logic                               i_ready,
    output logic                               o_valid,
    output logic signed [COORD_WIDTH-1:0]      o_x,
    output logic signed [COORD_WIDTH-1:0]      o_y,
    output logic signed [COORD_WIDTH-1:0]      o_z,
    output logic [lwi_pkg::IDX_WIDTH-1:0]      o_index,
    output logic                               o_last,
    output logic                               o_free
);

    logic                             r_valid;
    logic [COORD_WIDTH-1:0]           r_x;
    logic [COORD_WIDTH-1:0]           r_y;
    logic [COORD_WIDTH-1:0]           r_z;
    logic [lwi_pkg::IDX_WIDTH-1:0]    r_index;
    logic                             r_last;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_index = r_index;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x     <= i_x;
            r_y     <= i_y;
            r_z     <= i_z;
            r_index <= i_index;
            r_last  <= i_last;
        end
    end

endmodule

/* rtl/linear_waypoint_interpolator.sv */
// Channel   Direction  Handshake           Payload
// target    in         i_valid / o_ready   i_target_x, i_target_y, i_target_z
// waypoint  out        o_valid / i_ready   o_way_x, o_way_y, o_way_z, o_way_index, o_last
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// A target with n waypoints is loaded, the bit-serial divider in each axis lane then
// divides its distance by n + 1, a prime step follows, and one point per cycle is
// emitted while the output is not stalled. With n = 0 no point is emitted.
// Synchronous active-low reset clears the sequencer and output valid; start = home.
// A stalled output holds the lanes; the next target is taken once the last point is loaded.
module linear_waypoint_interpolator #(
    parameter int COORD_WIDTH   = lwi_pkg::COORD_WIDTH,
    parameter int FRAC_BITS     = lwi_pkg::FRAC_BITS,
    parameter int MAX_WAYPOINTS = lwi_pkg::MAX_WAYPOINTS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lwi_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]               i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [COORD_WIDTH-1:0]        i_target_x,
    input  logic signed [COORD_WIDTH-1:0]        i_target_y,
    input  logic signed [COORD_WIDTH-1:0]        i_target_z,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [COORD_WIDTH-1:0]        o_way_x,
    output logic signed [COORD_WIDTH-1:0]        o_way_y,
    output logic signed [COORD_WIDTH-1:0]        o_way_z,
    output logic [lwi_pkg::IDX_WIDTH-1:0]        o_way_index,
    output logic                                 o_last
);

    localparam int IDX_W   = lwi_pkg::IDX_WIDTH;
    localparam int PARTS_W = lwi_pkg::PARTS_WIDTH;
    localparam int CNT_W   = $clog2(COORD_WIDTH + 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(COORD_WIDTH);
    localparam logic [IDX_W-1:0] N_MAX    = IDX_W'(MAX_WAYPOINTS);
    localparam logic [COORD_WIDTH-1:0] START_X_RST =
        COORD_WIDTH'(lwi_pkg::HOME_X_UNITS) << FRAC_BITS;
    localparam logic [COORD_WIDTH-1:0] START_Y_RST =
        COORD_WIDTH'(lwi_pkg::HOME_Y_UNITS) << FRAC_BITS;
    localparam logic [COORD_WIDTH-1:0] START_Z_RST =
        COORD_WIDTH'(lwi_pkg::HOME_Z_UNITS) << FRAC_BITS;

    lwi_pkg::t_state        r_state;
    lwi_pkg::t_state        n_state;
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic [IDX_W-1:0]       r_k;
    logic [IDX_W-1:0]       n_k;
    logic [IDX_W-1:0]       r_num_wp;
    logic [IDX_W-1:0]       r_n;
    logic [PARTS_W-1:0]     r_parts;
    logic [COORD_WIDTH-1:0] r_start_x;
    logic [COORD_WIDTH-1:0] r_start_y;
    logic [COORD_WIDTH-1:0] r_start_z;

    logic [IDX_W-1:0]       w_n_sat;
    logic                   w_accept;
    logic                   w_emit;
    logic                   w_free;
    lwi_pkg::t_lane_ctl     w_ctl;
    logic [COORD_WIDTH-1:0] w_lane_x;
    logic [COORD_WIDTH-1:0] w_lane_y;
    logic [COORD_WIDTH-1:0] w_lane_z;

    assign w_n_sat  = (r_num_wp > N_MAX) ? N_MAX : r_num_wp;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_k        = r_k;
        o_ready    = 1'b0;
        w_emit     = 1'b0;
        w_ctl      = '0;
        case (r_state)
            lwi_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                w_ctl.load = i_valid;
                n_cnt      = '0;
                if (i_valid && (w_n_sat != '0)) begin
                    n_state = lwi_pkg::ST_DIVIDE;
                end
            end
            lwi_pkg::ST_DIVIDE: begin
                w_ctl.div = 1'b1;
                n_cnt     = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = lwi_pkg::ST_PRIME;
                end
            end
            lwi_pkg::ST_PRIME: begin
                w_ctl.step = 1'b1;
                n_k        = IDX_W'(1);
                n_state    = lwi_pkg::ST_EMIT;
            end
            lwi_pkg::ST_EMIT: begin
                if (w_free) begin
                    w_emit = 1'b1;
                    if (r_k == r_n) begin
                        n_state = lwi_pkg::ST_IDLE;
                    end else begin
                        w_ctl.step = 1'b1;
                        n_k        = r_k + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = lwi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lwi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_k       <= '0;
            r_num_wp  <= IDX_W'(lwi_pkg::NUM_WAYPOINTS_RESET);
            r_start_x <= START_X_RST;
            r_start_y <= START_Y_RST;
            r_start_z <= START_Z_RST;
        end else begin
            r_cnt <= n_cnt;
            r_k   <= n_k;
            if (i_cfg_we && (i_cfg_idx == lwi_pkg::REG_NUM_WAYPOINTS)) begin
                r_num_wp <= i_cfg_data[IDX_W-1:0];
            end
            if (w_accept) begin
                r_start_x <= i_target_x;
                r_start_y <= i_target_y;
                r_start_z <= i_target_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n     <= w_n_sat;
            r_parts <= {1'b0, w_n_sat} + PARTS_W'(1);
        end
    end

    lwi_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_start  (r_start_x),
        .i_target (i_target_x),
        .i_parts  (r_parts),
        .o_coord  (w_lane_x)
    );

    lwi_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_start  (r_start_y),
        .i_target (i_target_y),
        .i_parts  (r_parts),
        .o_coord  (w_lane_y)
    );

    lwi_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_z (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_start  (r_start_z),
        .i_target (i_target_z),
        .i_parts  (r_parts),
        .o_coord  (w_lane_z)
    );

    lwi_merge #(.COORD_WIDTH(COORD_WIDTH)) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_emit),
        .i_x      (w_lane_x),
        .i_y      (w_lane_y),
        .i_z      (w_lane_z),
        .i_index  (r_k),
        .i_last   (r_k == r_n),
        .i_ready  (i_ready),
        .o_valid  (o_valid),
        .o_x      (o_way_x),
        .o_y      (o_way_y),
        .o_z      (o_way_z),
        .o_index  (o_way_index),
        .o_last   (o_last),
        .o_free   (w_free)
    );

endmodule

/* rtl/lwi_checker.sv */
module lwi_checker #(
    parameter int COORD_WIDTH = lwi_pkg::COORD_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_ready,
    input  logic                               o_valid,
    input  logic                               i_ready,
    input  logic signed [COORD_WIDTH-1:0]      o_way_x,
    input  logic signed [COORD_WIDTH-1:0]      o_way_y,
    input  logic signed [COORD_WIDTH-1:0]      o_way_z,
    input  logic [lwi_pkg::IDX_WIDTH-1:0]      o_way_index,
    input  logic                               o_last
);

    logic [lwi_pkg::IDX_WIDTH-1:0] r_exp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= lwi_pkg::IDX_WIDTH'(1);
        end else if (o_valid && i_ready) begin
            r_exp_idx <= o_last ? lwi_pkg::IDX_WIDTH'(1)
                                : o_way_index + lwi_pkg::IDX_WIDTH'(1);
        end
    end

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_way_x) && $stable(o_way_y)
            && $stable(o_way_z) && $stable(o_way_index) && $stable(o_last))
        else $error("stalled waypoint changed");

    a_index_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_way_index == r_exp_idx)
        else $error("waypoint index out of sequence");

    a_ready_only_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && o_valid |-> o_last)
        else $error("target taken with run still pending");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind linear_waypoint_interpolator lwi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lwi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_way_x     (o_way_x),
    .o_way_y     (o_way_y),
    .o_way_z     (o_way_z),
    .o_way_index (o_way_index),
    .o_last      (o_last)
);
